### sv/radial_ripple_height_gen_core_defines.svh
// Assertion macros shared by the radial ripple checker.
`ifndef RADIAL_RIPPLE_HEIGHT_GEN_CORE_DEFINES_SVH
`define RADIAL_RIPPLE_HEIGHT_GEN_CORE_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define RRH_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// Consequence that must hold in the same cycle as its antecedent.
`define RRH_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

### sv/rrh_pkg.sv
// Shared types, constants and stage map of the radial ripple height generator.
package rrh_pkg;

  localparam int NUM_AXES = 4;
  localparam int COORD_W  = 16;
  localparam int AXIS_W   = 3;

  localparam logic [AXIS_W-1:0] AXIS_RESET = 3'd2;
  localparam logic [COORD_W-1:0] COORD_HALF = 16'h8000;

  localparam logic [32:0] ONE32 = 33'h1_0000_0000;
  localparam logic [34:0] PI32  = 35'h3_243F_6A88;
  localparam logic [34:0] TAU32 = 35'h6_487E_D511;
  localparam logic [29:0] PI28  = 30'h3243_F6A8;
  localparam logic [63:0] BHK_K64 = (64'd5 * 64'h3243_F6A8 * 64'h3243_F6A8) >> 28;
  localparam logic [33:0] BHK_K   = BHK_K64[33:0];
  localparam logic [27:0] HALF28  = 28'h800_0000;
  localparam logic [28:0] ONE28   = 29'h1000_0000;

  // Register index of axis_count.
  localparam logic REG_AXIS_COUNT = 1'b0;

  localparam int Q1_BITS    = 33;
  localparam int Q2_BITS    = 30;
  localparam int DIV5_STEPS = 6;

  // Stage map.
  localparam int ST_MAG   = 0;
  localparam int ST_SQ    = 1;
  localparam int ST_D2    = 2;
  localparam int ST_DIV1  = 3;
  localparam int ST_R     = ST_DIV1 + Q1_BITS;
  localparam int ST_T     = ST_R + 1;
  localparam int ST_MOD   = ST_T + 1;
  localparam int ST_ABS   = ST_MOD + 3;
  localparam int ST_P     = ST_ABS + 1;
  localparam int ST_N     = ST_P + 1;
  localparam int ST_DIV5  = ST_MOD;
  localparam int ST_DIV2  = ST_N + 1;
  localparam int ST_FADE  = ST_DIV2;
  localparam int ST_PROD  = ST_DIV2 + Q2_BITS;
  localparam int ST_H     = ST_PROD + 1;
  localparam int NSTAGES  = ST_H + 1;
  localparam int LATENCY  = NSTAGES;

  typedef struct packed {
    logic [31:0]             idx;
    logic [3:0][15:0]        mag;
    logic [3:0][30:0]        sq;
    logic                    zero;
    logic [32:0]             r1;
    logic [32:0]             rem1;
    logic [32:0]             dlo1;
    logic [32:0]             q1;
    logic [32:0]             r;
    logic [38:0]             ph;
    logic [35:0]             x5;
    logic [2:0]              rem5;
    logic [35:0]             sc;
    logic                    neg;
    logic [29:0]             ax;
    logic [29:0]             p;
    logic [33:0]             den;
    logic [33:0]             rem2;
    logic [29:0]             q2;
    logic [28:0]             fade;
    logic [27:0]             prod;
    logic [15:0]             h;
  } item_t;

endpackage

### sv/radial_ripple_height_gen_core.sv
// Radial ripple height generator: pipelined distance, sine, fade and height.
// One item enters per clock whenever start is high; busy never rises. Each item
// leaves the last pipeline stage with a one-cycle done strobe, in
// order. The depth is set by the two restoring dividers, one quotient bit per
// stage: 33 stages for the Newton radius step and 30 for the sine quotient.
// The receiver cannot stall, so results must be taken in the strobe cycle.
module radial_ripple_height_gen_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] cell_index,
  input  logic [15:0] coord_0,
  input  logic [15:0] coord_1,
  input  logic [15:0] coord_2,
  input  logic [15:0] coord_3,
  output logic        done,
  output logic [31:0] out_index,
  output logic [15:0] height,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [rrh_pkg::AXIS_W-1:0] axis_count;
  rrh_pkg::item_t st [rrh_pkg::NSTAGES];
  rrh_pkg::item_t nx [rrh_pkg::NSTAGES];
  logic [rrh_pkg::NSTAGES-1:0] v;

  // Config register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == rrh_pkg::REG_AXIS_COUNT) ? {29'd0, axis_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_count <= rrh_pkg::AXIS_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == rrh_pkg::REG_AXIS_COUNT) begin
      axis_count <= pwdata[rrh_pkg::AXIS_W-1:0];
    end
  end

  assign busy = 1'b0;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[rrh_pkg::NSTAGES-2:0], start & ~busy};
    end
  end

  // Input stage: offset magnitudes of active axes
  always_comb begin
    logic [3:0][15:0] c;
    c = {coord_3, coord_2, coord_1, coord_0};
    nx[0] = '0;
    nx[0].idx = cell_index;
    for (int k = 0; k < rrh_pkg::NUM_AXES; k++) begin
      if (axis_count > k[rrh_pkg::AXIS_W-1:0]) begin
        nx[0].mag[k] = (c[k] >= rrh_pkg::COORD_HALF) ? c[k] - rrh_pkg::COORD_HALF
                                                      : rrh_pkg::COORD_HALF - c[k];
      end else begin
        nx[0].mag[k] = 16'd0;
      end
    end
  end

  for (genvar g = 1; g < rrh_pkg::NSTAGES; g++) begin : g_stage
    always_comb begin
      nx[g] = st[g-1];

      // Square each offset
      if (g == rrh_pkg::ST_SQ) begin : sq_step
        for (int k = 0; k < rrh_pkg::NUM_AXES; k++) begin
          nx[g].sq[k] = 31'(32'(st[g-1].mag[k]) * 32'(st[g-1].mag[k]));
        end
      end

      // Sum squares, seed Newton step, load divider
      if (g == rrh_pkg::ST_D2) begin : d2_step
        logic [32:0] d2;
        logic [33:0] s;
        d2 = 33'(st[g-1].sq[0]) + 33'(st[g-1].sq[1]) +
             33'(st[g-1].sq[2]) + 33'(st[g-1].sq[3]);
        s = {1'b0, d2} + {1'b0, rrh_pkg::ONE32};
        nx[g].zero = (d2 == 33'd0);
        nx[g].r1   = s[33:1];
        nx[g].rem1 = {1'b0, d2[32:1]};
        nx[g].dlo1 = {d2[0], 32'd0};
        nx[g].q1   = '0;
      end

      // One quotient bit of d2 / r1
      if (g >= rrh_pkg::ST_DIV1 && g < rrh_pkg::ST_R) begin : div1_step
        logic [33:0] t;
        logic        qb;
        t  = {st[g-1].rem1, st[g-1].dlo1[32]};
        qb = (t >= {1'b0, st[g-1].r1});
        nx[g].rem1 = qb ? 33'(t - {1'b0, st[g-1].r1}) : t[32:0];
        nx[g].dlo1 = {st[g-1].dlo1[31:0], 1'b0};
        nx[g].q1   = {st[g-1].q1[31:0], qb};
      end

      // Finish Newton step
      if (g == rrh_pkg::ST_R) begin : r_step
        logic [33:0] s;
        s = {1'b0, st[g-1].r1} + {1'b0, st[g-1].q1};
        nx[g].r = st[g-1].zero ? 33'd0 : s[33:1];
      end

      // Phase r*40 offset by pi; load divide by five
      if (g == rrh_pkg::ST_T) begin : t_step
        logic [38:0] rw;
        rw = 39'(st[g-1].r);
        nx[g].ph   = (rw << 5) + (rw << 3) + 39'(rrh_pkg::PI32);
        nx[g].x5   = {st[g-1].r, 3'b000};
        nx[g].rem5 = 3'd0;
        nx[g].sc   = '0;
      end

      // Reduce phase modulo tau
      if (g >= rrh_pkg::ST_MOD && g < rrh_pkg::ST_ABS) begin : mod_step
        logic [38:0] sub;
        sub = 39'(rrh_pkg::TAU32) << (rrh_pkg::ST_ABS - 1 - g);
        if (st[g-1].ph >= sub) begin
          nx[g].ph = st[g-1].ph - sub;
        end
      end

      // Several bits of r*8 / 5
      if (g >= rrh_pkg::ST_DIV5 && g < rrh_pkg::ST_DIV5 + rrh_pkg::DIV5_STEPS) begin : div5_step
        logic [3:0]  t;
        logic [2:0]  rm;
        logic [35:0] xs;
        logic [35:0] qs;
        rm = st[g-1].rem5;
        xs = st[g-1].x5;
        qs = st[g-1].sc;
        for (int i = 0; i < rrh_pkg::DIV5_STEPS; i++) begin
          t  = {rm, xs[35]};
          xs = {xs[34:0], 1'b0};
          if (t >= 4'd5) begin
            rm = 3'(t - 4'd5);
            qs = {qs[34:0], 1'b1};
          end else begin
            rm = t[2:0];
            qs = {qs[34:0], 1'b0};
          end
        end
        nx[g].rem5 = rm;
        nx[g].x5   = xs;
        nx[g].sc   = qs;
      end

      // Sign and magnitude of reduced phase
      if (g == rrh_pkg::ST_ABS) begin : abs_step
        logic [34:0] m;
        logic [34:0] dif;
        logic [30:0] a;
        m   = st[g-1].ph[34:0];
        nx[g].neg = (m < rrh_pkg::PI32);
        dif = (m < rrh_pkg::PI32) ? rrh_pkg::PI32 - m : m - rrh_pkg::PI32;
        a   = dif[34:4];
        nx[g].ax = (a > 31'(rrh_pkg::PI28)) ? rrh_pkg::PI28 : a[29:0];
      end

      // Bhaskara product term
      if (g == rrh_pkg::ST_P) begin : p_step
        logic [59:0] pr;
        pr = 60'(st[g-1].ax) * 60'(rrh_pkg::PI28 - st[g-1].ax);
        nx[g].p = pr[57:28];
      end

      // Load sine divider
      if (g == rrh_pkg::ST_N) begin : n_step
        nx[g].den  = rrh_pkg::BHK_K - {2'b00, st[g-1].p, 2'b00};
        nx[g].rem2 = {2'b00, st[g-1].p, 2'b00};
        nx[g].q2   = '0;
      end

      // One quotient bit of 16p / den
      if (g >= rrh_pkg::ST_DIV2 && g < rrh_pkg::ST_PROD) begin : div2_step
        logic [34:0] t;
        logic        qb;
        t  = {st[g-1].rem2, 1'b0};
        qb = (t >= {1'b0, st[g-1].den});
        nx[g].rem2 = qb ? 34'(t - {1'b0, st[g-1].den}) : t[33:0];
        nx[g].q2   = {st[g-1].q2[28:0], qb};
      end

      // Clamp r*1.6 and form fade
      if (g == rrh_pkg::ST_FADE) begin : fade_step
        logic [32:0] scc;
        logic [32:0] f;
        scc = (st[g-1].sc > 36'(rrh_pkg::ONE32)) ? rrh_pkg::ONE32 : st[g-1].sc[32:0];
        f   = rrh_pkg::ONE32 - scc;
        nx[g].fade = f[32:4];
      end

      // Ripple times fade, halved
      if (g == rrh_pkg::ST_PROD) begin : prod_step
        logic [58:0] pr;
        pr = 59'(st[g-1].q2) * 59'(st[g-1].fade);
        nx[g].prod = pr[56:29];
      end

      // Offset, clamp and truncate height
      if (g == rrh_pkg::ST_H) begin : h_step
        logic [28:0] h28;
        if (st[g-1].neg) begin
          h28 = (st[g-1].prod >= rrh_pkg::HALF28) ? 29'd0
                : 29'(rrh_pkg::HALF28 - st[g-1].prod);
        end else begin
          h28 = 29'(rrh_pkg::HALF28) + 29'(st[g-1].prod);
        end
        if (h28 > rrh_pkg::ONE28) begin
          h28 = rrh_pkg::ONE28;
        end
        nx[g].h = (h28[28:12] > 17'h0FFFF) ? 16'hFFFF : h28[27:12];
      end
    end
  end

  // Hold pipeline payload
  for (genvar g = 0; g < rrh_pkg::NSTAGES; g++) begin : g_reg
    always_ff @(posedge clk) begin
      st[g] <= nx[g];
    end
  end

  assign done      = v[rrh_pkg::NSTAGES-1];
  assign out_index = st[rrh_pkg::NSTAGES-1].idx;
  assign height    = st[rrh_pkg::NSTAGES-1].h;

endmodule

### sv/rrh_checker.sv
// Port-level checker for the radial ripple height generator, with its bind.
`include "radial_ripple_height_gen_core_defines.svh"

module rrh_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [31:0] cell_index,
  input logic        done,
  input logic [31:0] out_index,
  input logic        pready
);

  // Never refuse an item
  `RRH_ASSERT_ALWAYS(a_never_busy, !busy, "busy rose")

  // Config port never waits
  `RRH_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")

  // Every strobe follows a start by the pipeline depth
  `RRH_ASSERT_IMPLY(a_done_after_start, done, $past(start, rrh_pkg::LATENCY), "stray result")

  // Index travels with its item
  `RRH_ASSERT_IMPLY(a_index_kept, done, out_index == $past(cell_index, rrh_pkg::LATENCY), "index mismatch")

endmodule

bind radial_ripple_height_gen_core rrh_checker u_rrh_checker (.*);

### verif/radial_ripple_height_gen_core_tb.sv
// Self-checking testbench for the radial ripple height generator core.
`timescale 1ns / 1ps

module radial_ripple_height_gen_core_tb;

  localparam logic [2:0] AXIS_COUNT_ADDR = {rrh_pkg::REG_AXIS_COUNT, 2'b00};
  localparam logic [2:0] SPARE_ADDR      = 3'd4;
  localparam int         IDLE_LIMIT      = 2000;
  localparam int         RANDOM_ITEMS    = 1130;

  localparam longint unsigned Q32_ONE  = 64'h1_0000_0000;
  localparam longint unsigned Q28_ONE  = 64'h1000_0000;
  localparam longint unsigned Q32_PI   = 64'h3_243F_6A88;
  localparam longint unsigned Q32_TAU  = 64'h6_487E_D511;

  typedef struct {
    logic [2:0]  axes;
    logic [31:0] idx;
    logic [15:0] c0, c1, c2, c3;
    bit          typed;
    logic [15:0] h;
  } row_t;

  typedef struct {
    logic [31:0] idx;
    logic [15:0] h;
  } height_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] cell_index = '0;
  logic [15:0] coord_0 = '0, coord_1 = '0, coord_2 = '0, coord_3 = '0;
  logic        done;
  logic [31:0] out_index;
  logic [15:0] height;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  height_t     pending_q[$];
  logic [2:0]  axis_cfg;
  int          errors = 0;
  int          idle_cycles = 0;
  row_t        dir_rows[$];

  radial_ripple_height_gen_core i_dut (.*);

  always #1 clk = ~clk;

  // Predict the height of one cell for a given axis count.
  function automatic logic [15:0] ripple_height(logic [2:0] axes, logic [15:0] c0,
                                                logic [15:0] c1, logic [15:0] c2,
                                                logic [15:0] c3);
    logic [15:0] crd[4];
    longint unsigned n, mag, d2, r1, q, r, t, m, ax, pi28, p, den, s, sc, fade,
                     prod, h28, h;
    bit neg;
    crd = '{c0, c1, c2, c3};
    n = (axes > 4) ? 4 : axes;
    d2 = 0;
    r = 0;
    for (int k = 0; k < n; k++) begin
      mag = (crd[k] >= 16'h8000) ? crd[k] - 16'h8000 : 16'h8000 - crd[k];
      d2 += mag * mag;
    end
    // one Newton step seeded with (d2 + 1) / 2
    if (d2 != 0) begin
      r1 = (d2 + Q32_ONE) >> 1;
      q = ((d2 / r1) << 32) + (((d2 % r1) << 32) / r1);
      r = (r1 + q) >> 1;
    end
    // Bhaskara sine after floored reduction
    pi28 = Q32_PI >> 4;
    t = r * 40;
    m = (t + Q32_PI) % Q32_TAU;
    neg = (m < Q32_PI);
    ax = (neg ? Q32_PI - m : m - Q32_PI) >> 4;
    if (ax > pi28) ax = pi28;
    p = (ax * (pi28 - ax)) >> 28;
    den = ((5 * pi28 * pi28) >> 28) - 4 * p;
    s = ((16 * p) << 28) / den;
    // linear fade and final height
    sc = (r * 8) / 5;
    if (sc > Q32_ONE) sc = Q32_ONE;
    fade = (Q32_ONE - sc) >> 4;
    prod = (s * fade) >> 29;
    if (neg) h28 = (prod >= (Q28_ONE >> 1)) ? 0 : (Q28_ONE >> 1) - prod;
    else h28 = (Q28_ONE >> 1) + prod;
    if (h28 > Q28_ONE) h28 = Q28_ONE;
    h = h28 >> 12;
    if (h > 16'hFFFF) h = 16'hFFFF;
    return h[15:0];
  endfunction

  // Spread coordinates over center, extremes and the whole range.
  function automatic logic [15:0] pick_coord();
    unique case ($urandom_range(0, 5))
      0: return 16'h8000 + 16'($urandom_range(0, 511)) - 16'd256;
      1: return 16'h8000 + 16'($urandom_range(0, 8191)) - 16'd4096;
      2: return $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Count idle cycles and check each result against the oldest prediction.
  always @(posedge clk) begin
    height_t want;
    if (!rst) begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
      if (done) begin
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected result index %h height %h", $time, out_index, height);
          errors++;
        end else begin
          want = pending_q.pop_front();
          if (out_index !== want.idx) begin
            $display("%0t: out_index expected %h actual %h", $time, want.idx, out_index);
            errors++;
          end
          if (height !== want.h) begin
            $display("%0t: height expected %h actual %h (index %h)", $time, want.h,
                     height, want.idx);
            errors++;
          end
        end
      end
    end
  end

  // Wait until every predicted result has come back.
  task automatic drain();
    while (pending_q.size() != 0) @(negedge clk);
  endtask

  // Write one register over the APB port while idle.
  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    drain();
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; paddr = addr; pwdata = value; penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == AXIS_COUNT_ADDR) axis_cfg = value[2:0];
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // Present one item after a random gap and hold it until accepted.
  task automatic send_item(row_t row);
    int gap;
    height_t want;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    cell_index = row.idx;
    coord_0 = row.c0; coord_1 = row.c1; coord_2 = row.c2; coord_3 = row.c3;
    do @(posedge clk); while (busy);
    want.idx = row.idx;
    want.h = row.typed ? row.h
                       : ripple_height(axis_cfg, row.c0, row.c1, row.c2, row.c3);
    pending_q.push_back(want);
    @(negedge clk);
  endtask

  // Drop start and switch the axis count when a new setting is asked for.
  task automatic run_row(row_t row);
    if (row.axes != axis_cfg) begin
      start = 1'b0;
      write_reg(AXIS_COUNT_ADDR, {29'h0, row.axes});
    end
    send_item(row);
  endtask

  initial begin
    row_t row;
    logic [2:0] phase_axes[$];
    int phase, left;

    axis_cfg = rrh_pkg::AXIS_RESET;
    // directed items: centre, zero axes, extremes and saturated axis counts
    dir_rows = '{
      '{3'd2, 32'h0000_0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1, 16'h8000},
      '{3'd2, 32'hFFFF_FFFF, 16'h8000, 16'h8000, 16'h1234, 16'hFFFF, 1, 16'h8000},
      '{3'd2, 32'h0000_0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 16'h0},
      '{3'd2, 32'h8000_0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 16'h0},
      '{3'd2, 32'h5555_5555, 16'h8001, 16'h7FFF, 16'h0, 16'h0, 0, 16'h0},
      '{3'd0, 32'hAAAA_AAAA, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 1, 16'h8000},
      '{3'd0, 32'h0000_FFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1, 16'h8000},
      '{3'd1, 32'h0000_0002, 16'h0000, 16'h0, 16'h0, 16'h0, 0, 16'h0},
      '{3'd1, 32'h0000_0003, 16'hFFFF, 16'h0, 16'h0, 16'h0, 0, 16'h0},
      '{3'd1, 32'h0000_0004, 16'h8100, 16'h0, 16'h0, 16'h0, 0, 16'h0},
      '{3'd1, 32'h0000_0005, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 16'h8000},
      '{3'd3, 32'h0000_0006, 16'h0000, 16'hFFFF, 16'h0000, 16'h8000, 0, 16'h0},
      '{3'd4, 32'h0000_0007, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 16'h0},
      '{3'd4, 32'h0000_0008, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 16'h0},
      '{3'd4, 32'h0000_0009, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 0, 16'h0},
      '{3'd4, 32'h0000_000A, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1, 16'h8000},
      '{3'd5, 32'h0000_000B, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 0, 16'h0},
      '{3'd7, 32'h0000_000C, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 16'h0},
      '{3'd7, 32'h0000_000D, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1, 16'h8000},
      '{3'd6, 32'h0000_000E, 16'h7000, 16'h9000, 16'h6000, 16'hA000, 0, 16'h0}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) run_row(dir_rows[i]);

    // a write to an unused address must leave the axis count alone
    start = 1'b0;
    write_reg(SPARE_ADDR, 32'hFFFF_FFFF);

    // random phases, each under its own axis count
    phase_axes = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd3, 3'd2, 3'd5, 3'd4, 3'd6, 3'd1};
    left = RANDOM_ITEMS;
    phase = 0;
    while (left > 0) begin
      row.axes = (phase < phase_axes.size()) ? phase_axes[phase]
                                              : 3'($urandom_range(1, 4));
      row.typed = 0;
      row.h = '0;
      for (int i = 0; i < 100 && left > 0; i++) begin
        row.idx = $urandom;
        row.c0 = pick_coord(); row.c1 = pick_coord();
        row.c2 = pick_coord(); row.c3 = pick_coord();
        run_row(row);
        left--;
      end
      phase++;
    end
    start = 1'b0;

    drain();
    repeat (rrh_pkg::LATENCY + 10) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
